// ===== hw/rtl/b64enc_pkg.sv =====
// Shared types, constants and the character lookup for the Base64 stream encoder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package b64enc_pkg;

    // Default depth of the group queue between front and back
    localparam int QueueDepth = 2;

    // ASCII anchors of the standard alphabet
    localparam logic [6:0] PadChar   = 7'd61;  // '='
    localparam logic [6:0] PlusChar  = 7'd43;  // '+'
    localparam logic [6:0] SlashChar = 7'd47;  // '/'
    localparam logic [6:0] UpperBase = 7'd65;  // 'A'
    localparam logic [6:0] LowerOffs = 7'd71;  // 'a' minus 26
    localparam logic [6:0] DigitOffs = 7'd4;   // 52 minus '0'

    // One closed 24-bit group with its padding count and end-of-message flag
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pads;
        logic        fin;
    } group_t;

    // Map a 6-bit slice to its alphabet character
    function automatic logic [6:0] enc_char(input logic [5:0] idx);
        logic [6:0] ch;
        case (idx) inside
            [6'd0:6'd25]:  ch = {1'b0, idx} + UpperBase;
            [6'd26:6'd51]: ch = {1'b0, idx} + LowerOffs;
            [6'd52:6'd61]: ch = {1'b0, idx} - DigitOffs;
            6'd62:         ch = PlusChar;
            default:       ch = SlashChar;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64enc_front.sv =====
// Front end: takes bytes, gathers them into 24-bit groups and closes a group
// when it is full or the message ends. Depends on b64enc_pkg.
`default_nettype none

module b64enc_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    input  wire logic                byte_valid,
    output logic                     byte_ready,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output b64enc_pkg::group_t       push_data
);

    logic [15:0] group_bytes_reg, group_bytes_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic [1:0]  held;
    logic        take;
    logic        close_grp;

    // Stall input while the queue has no room for a closed group
    assign byte_ready = push_ready;
    assign take       = byte_valid && byte_ready;

    // Classify the byte: extend the open group or close it
    always_comb
    begin
        held = (group_count_reg == 2'd3) ? 2'd2 : group_count_reg;
        close_grp = last_byte || (held == 2'd2);

        push_data.fin = last_byte;
        case (held)
            2'd2:
            begin
                push_data.word = {group_bytes_reg, data_byte};
                push_data.pads = 2'd0;
            end
            2'd1:
            begin
                push_data.word = {group_bytes_reg[7:0], data_byte, 8'h00};
                push_data.pads = 2'd1;
            end
            default:
            begin
                push_data.word = {data_byte, 16'h0000};
                push_data.pads = 2'd2;
            end
        endcase

        push_valid = byte_valid && close_grp;

        group_bytes_next = group_bytes_reg;
        group_count_next = group_count_reg;
        if (take)
        begin
            if (close_grp)
            begin
                group_bytes_next = '0;
                group_count_next = '0;
            end
            else
            begin
                group_bytes_next = {group_bytes_reg[7:0], data_byte};
                group_count_next = held + 2'd1;
            end
        end
    end

    // Hold the open group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bytes_reg <= '0;
            group_count_reg <= '0;
        end
        else
        begin
            group_bytes_reg <= group_bytes_next;
            group_count_reg <= group_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64enc_queue.sv =====
// Short queue of closed groups between the front and back ends.
// Depends on b64enc_pkg for the group type.
`default_nettype none

module b64enc_queue
#(
    parameter int Depth = b64enc_pkg::QueueDepth
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire b64enc_pkg::group_t  push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output b64enc_pkg::group_t       pop_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    b64enc_pkg::group_t slots [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed group
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64enc_back.sv =====
// Back end: takes one closed group at a time and emits its four characters,
// one per cycle while char_ready is high, through an output register. Depends on b64enc_pkg.
`default_nettype none

module b64enc_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire b64enc_pkg::group_t  pop_data,
    output logic [6:0]               b64_char,
    output logic                     last_char,
    output logic                     char_valid,
    input  wire logic                char_ready
);

    b64enc_pkg::group_t grp_reg, grp_next;
    logic        have_reg, have_next;
    logic [1:0]  slot_reg, slot_next;
    logic [6:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic        valid_reg, valid_next;
    logic        out_free, step, done_grp, load;
    logic [5:0]  slice;
    logic        is_pad;

    assign out_free  = !valid_reg || char_ready;
    assign step      = have_reg && out_free;
    assign done_grp  = step && (slot_reg == 2'd3);
    assign pop_ready = !have_reg || done_grp;
    assign load      = pop_valid && pop_ready;

    assign b64_char   = char_reg;
    assign last_char  = last_reg;
    assign char_valid = valid_reg;

    // Pick the slice for the current slot and decide padding
    always_comb
    begin
        case (slot_reg)
            2'd0:    slice = grp_reg.word[23:18];
            2'd1:    slice = grp_reg.word[17:12];
            2'd2:    slice = grp_reg.word[11:6];
            default: slice = grp_reg.word[5:0];
        endcase
        is_pad = ({1'b0, slot_reg} + {1'b0, grp_reg.pads}) >= 3'd4;
    end

    // Advance through the group and refill from the queue
    always_comb
    begin
        grp_next   = grp_reg;
        have_next  = have_reg;
        slot_next  = slot_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;

        if (char_ready)
            valid_next = 1'b0;

        if (step)
        begin
            char_next  = is_pad ? b64enc_pkg::PadChar : b64enc_pkg::enc_char(slice);
            last_next  = grp_reg.fin && (slot_reg == 2'd3);
            valid_next = 1'b1;
            slot_next  = slot_reg + 2'd1;
            if (done_grp)
                have_next = 1'b0;
        end

        if (load)
        begin
            grp_next  = pop_data;
            have_next = 1'b1;
            slot_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            have_reg  <= have_next;
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_encoder_core.sv =====
// Top level of the Base64 stream encoder: front end, group queue, back end.
// Depends on b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
//
// Bytes enter one per cycle on data_byte/last_byte while byte_ready is high;
// characters of the standard alphabet, with '=' padding, leave one per cycle
// on b64_char while char_ready is high, and last_char marks the final
// character of each message. Every closed group yields exactly four
// characters, a partial group at the end of a message included, and the back
// end emits them at one per cycle while char_ready is high, so the output
// carries four characters for every three bytes of a full group.
// The group queue (QueueDepth entries) lets the front end take bytes while
// the back end still serializes earlier groups; input stalls only while the
// queue is full. The group that a byte closes passes through a queue slot, the
// back end's group register and the output register.
`default_nettype none

module base64_stream_encoder_core
#(
    parameter int QueueDepth = b64enc_pkg::QueueDepth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    output logic [6:0]       b64_char,
    output logic             last_char,
    output logic             char_valid,
    input  wire logic        char_ready
);

    b64enc_pkg::group_t push_data, pop_data;
    logic push_valid, push_ready, pop_valid, pop_ready;

    b64enc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64enc_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64enc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .b64_char   (b64_char),
        .last_char  (last_char),
        .char_valid (char_valid),
        .char_ready (char_ready)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/b64enc_checker.sv =====
// Port-level checks for the Base64 stream encoder, bound to the top level.
// Depends on b64enc_pkg for the padding character.
`default_nettype none

module b64enc_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [6:0]  b64_char,
    input  wire logic        last_char,
    input  wire logic        char_valid,
    input  wire logic        char_ready
);

    logic [1:0] pos_reg;
    logic       prev_pad_reg;
    logic       out_take;
    logic       cur_pad;

    assign out_take = char_valid && char_ready;
    assign cur_pad  = (b64_char == b64enc_pkg::PadChar);

    // Track the position of each delivered item within its group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            prev_pad_reg <= 1'b0;
        end
        else if (out_take)
        begin
            pos_reg      <= pos_reg + 2'd1;
            prev_pad_reg <= cur_pad;
        end
    end

    // A pending item holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(b64_char) && $stable(last_char))
        else $error("output item changed while stalled");

    // Message end only on the fourth character of a group
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && last_char |-> pos_reg == 2'd3)
        else $error("last_char off the fourth character");

    // Padding never in the first two characters
    a_pad_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && cur_pad |-> pos_reg == 2'd2 || pos_reg == 2'd3)
        else $error("padding in a leading position");

    // Padding in the third place forces padding in the fourth
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && pos_reg == 2'd3 && prev_pad_reg |-> cur_pad)
        else $error("padding run broken");

    // Padding closes a message
    a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && pos_reg == 2'd3 && cur_pad |-> last_char)
        else $error("padded group without message end");

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .b64_char   (b64_char),
    .last_char  (last_char),
    .char_valid (char_valid),
    .char_ready (char_ready)
);

`default_nettype wire

// ===== bench/base64_stream_encoder_core_test.sv =====
// Self-checking bench for base64_stream_encoder_core: directed groups, then random messages.
// Depends on b64enc_pkg (PadChar) and the encoder RTL; expected characters come from a local model.

module base64_stream_encoder_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBytes = 100;
    localparam int HoldCycles  = 80;
    localparam int QuietLimit  = 1000;
    localparam int DrainCycles = 8;

    // Standard alphabet, first character in the top byte
    localparam logic [511:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One expected output character
    typedef struct packed {
        logic [6:0] code;
        logic       fin;
    } enc_char_t;

    // One directed byte; text holds four typed characters when typed is set
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        typed;
        logic [31:0] text;
    } byte_row_t;

    localparam int NumRows = 21;
    localparam byte_row_t DirectedBytes [NumRows] = '{
        // single zero byte, two pads
        '{8'h00, 1'b1, 1'b1, "AA=="},
        // single all-ones byte, two pads
        '{8'hFF, 1'b1, 1'b1, "/w=="},
        // full group closed by the final byte, no padding
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b1, "////"},
        // full group in the middle of a message
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, "AAAA"},
        // two-byte tail, one pad
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b1, "//8="},
        // new message: two zero bytes, one pad
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b1, "AAA="},
        // plus sign in every position, then a lone zero byte closing the message
        '{8'hFB, 1'b0, 1'b0, 32'h0},
        '{8'hEF, 1'b0, 1'b0, 32'h0},
        '{8'hBE, 1'b0, 1'b1, "++++"},
        '{8'h00, 1'b1, 1'b1, "AA=="},
        // mixed letters, then a two-byte tail with a digit and one pad
        '{8'h4D, 1'b0, 1'b0, 32'h0},
        '{8'h61, 1'b0, 1'b0, 32'h0},
        '{8'h6E, 1'b1, 1'b1, "TWFu"},
        '{8'h66, 1'b0, 1'b0, 32'h0},
        '{8'h6F, 1'b1, 1'b1, "Zm8="}
    };

    logic       clk;
    logic       rst_n      = 1'b0;
    logic [7:0] data_byte  = 8'h00;
    logic       last_byte  = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    logic [6:0] b64_char;
    logic       last_char;
    logic       char_valid;
    logic       char_ready = 1'b0;

    // Encoder model state
    logic [15:0] held_bytes = '0;
    logic [1:0]  held_count = '0;

    enc_char_t expected_chars [$];

    int errors      = 0;
    int bytes_in    = 0;
    int chars_out   = 0;
    int messages    = 0;
    int one_pad     = 0;
    int two_pad     = 0;
    int quiet       = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;

    base64_stream_encoder_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .b64_char   (b64_char),
        .last_char  (last_char),
        .char_valid (char_valid),
        .char_ready (char_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the model by one accepted byte and queue any characters it closes
    task automatic encode_byte(input logic [7:0] d, input logic fin,
                               input logic typed, input logic [31:0] text);
        logic [1:0]  held;
        logic [2:0]  n;
        logic [23:0] word;
        logic [1:0]  pads;
        logic [5:0]  idx;
        enc_char_t   c;
        held = (held_count > 2'd2) ? 2'd2 : held_count;
        n = {1'b0, held} + 3'd1;
        bytes_in++;
        if (n < 3'd3 && !fin)
        begin
            held_bytes = {held_bytes[7:0], d};
            held_count = n[1:0];
            return;
        end
        case (n)
            3'd3:    word = {held_bytes, d};
            3'd2:    word = {held_bytes[7:0], d, 8'h00};
            default: word = {d, 16'h0000};
        endcase
        pads = (n == 3'd3) ? 2'd0 : (n == 3'd2) ? 2'd1 : 2'd2;
        if (pads == 2'd1) one_pad++;
        if (pads == 2'd2) two_pad++;
        if (fin) messages++;
        for (int k = 0; k < 4; k++)
        begin
            idx = word[18 - 6 * k +: 6];
            if (k >= 4 - pads)
                c.code = b64enc_pkg::PadChar;
            else
                c.code = Alphabet[510 - 8 * int'(idx) -: 7];
            if (typed)
                c.code = text[30 - 8 * k -: 7];
            c.fin = fin && (k == 3);
            expected_chars.push_back(c);
        end
        held_bytes = '0;
        held_count = '0;
    endtask

    // Offer one item from a falling edge, hold it until taken, return on a falling edge
    task automatic offer_byte(input logic [7:0] d, input logic fin,
                              input logic typed, input logic [31:0] text);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 11) gap++;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= d;
        last_byte  <= fin;
        do @(posedge clk); while (!byte_ready);
        encode_byte(d, fin, typed, text);
        @(negedge clk);
    endtask

    // Drive char_ready: random stalls, quiet stretch, one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                char_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HoldCycles - 1;
                char_ready <= 1'b0;
            end
            else
                char_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Check each accepted character against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, actual %0d last %0b",
                         $time, b64_char, last_char);
                errors++;
            end
            else
            begin
                enc_char_t want;
                want = expected_chars.pop_front();
                chars_out++;
                if (b64_char !== want.code)
                begin
                    $display("%0t: b64_char mismatch: expected %0d, actual %0d",
                             $time, want.code, b64_char);
                    errors++;
                end
                if (last_char !== want.fin)
                begin
                    $display("%0t: last_char mismatch: expected %0b, actual %0b",
                             $time, want.fin, last_char);
                    errors++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (char_valid && char_ready))
            quiet <= 0;
        else if (quiet >= QuietLimit)
        begin
            $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
            $display("FAILURE");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int sent;
        int len;
        int sel;
        logic [7:0] d;

        // Hold reset, release on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed rows
        for (int i = 0; i < NumRows; i++)
            offer_byte(DirectedBytes[i].data, DirectedBytes[i].fin,
                       DirectedBytes[i].typed, DirectedBytes[i].text);

        // Random messages, mostly short, a few long
        sent = 0;
        while (sent < RandomBytes)
        begin
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 7) : $urandom_range(8, 24);
            for (int j = 0; j < len; j++)
            begin
                sel = $urandom_range(9);
                d = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
                offer_byte(d, j == len - 1, 1'b0, 32'h0);
                sent++;
                if (sent == 30) calm = 1'b1;
                if (sent == 60) calm = 1'b0;
                if (sent == 70) hold_req = 1'b1;
            end
        end
        byte_valid <= 1'b0;

        // Drain, then allow the pipeline to settle
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Encoded %0d bytes across %0d messages, %0d characters checked.",
                 bytes_in, messages, chars_out);
        $display("Tails: %0d with one pad, %0d with two pads; one %0d-cycle output hold-off.",
                 one_pad, two_pad, HoldCycles);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/b64enc_pkg.sv
hw/rtl/b64enc_front.sv
hw/rtl/b64enc_queue.sv
hw/rtl/b64enc_back.sv
hw/rtl/base64_stream_encoder_core.sv
hw/rtl/b64enc_checker.sv
bench/base64_stream_encoder_core_test.sv
